// ===== hdl/pmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrd_pkg
// Shared constants, access codes and controller/datapath signal groups for
// the port-mapped RAM disk.
// ----------------------------------------------------------------------------
package pmrd_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 24;
    localparam int EXT_W       = POS_W + 1;
    localparam int SIZE_W      = 17;
    localparam int FUNC_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [FUNC_W-1:0] FN_RD_CTL   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_WR_CTL   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_RD_DATA  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_WR_DATA  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_RD_ADDR0 = 4'd4;
    localparam logic [FUNC_W-1:0] FN_RD_ADDR1 = 4'd5;
    localparam logic [FUNC_W-1:0] FN_RD_ADDR2 = 4'd6;
    localparam logic [FUNC_W-1:0] FN_WR_ADDR0 = 4'd7;
    localparam logic [FUNC_W-1:0] FN_WR_ADDR1 = 4'd8;
    localparam logic [FUNC_W-1:0] FN_WR_ADDR2 = 4'd9;
    localparam logic [FUNC_W-1:0] FN_WR_SEQ   = 4'd10;
    localparam logic [FUNC_W-1:0] FN_INC      = 4'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE = 1'd1;

    localparam logic [1:0] SEL_BYTE0 = 2'd0;
    localparam logic [1:0] SEL_BYTE1 = 2'd1;
    localparam logic [1:0] SEL_BYTE2 = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_imm;
        logic load_mem;
    } dp_cmd_t;

    typedef struct packed {
        logic mem_read;
    } dp_status_t;

endpackage

// ===== hdl/port_mapped_ram_disk_core.sv =====
// ----------------------------------------------------------------------------
// port_mapped_ram_disk_core
// RAM disk reached through byte-wide port accesses: 64 KiB byte store,
// 24-bit position, sequential address byte counter.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   s_      | in        | s_valid / s_ready     | s_func[3:0], s_wdata[7:0]
//   m_      | out       | m_valid / m_ready     | m_rdata[7:0]
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index[0], cfg_data[16:0]
//
// A data read waits for the store's registered read port in ST_MEM and
// blocks new items meanwhile; all other items can follow back to back.
// The result byte sits in an output register; a new item is taken as that
// register is emptied.
// Reset is synchronous and needs no store clearing; store contents are
// undefined until written.
// ----------------------------------------------------------------------------
module port_mapped_ram_disk_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pmrd_pkg::FUNC_W-1:0]    s_func,
    input  logic [pmrd_pkg::BYTE_W-1:0]    s_wdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pmrd_pkg::BYTE_W-1:0]    m_rdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmrd_pkg::SIZE_W-1:0]    cfg_data
);
    import pmrd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pmrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pmrd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_func    (s_func),
        .s_wdata   (s_wdata),
        .m_rdata   (m_rdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hdl/pmrd_ram.sv =====
// ----------------------------------------------------------------------------
// pmrd_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module pmrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pmrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmrd_ctrl
// Access sequencer: input/output handshakes and datapath load commands.
// ----------------------------------------------------------------------------
module pmrd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  pmrd_pkg::dp_status_t status,
    output pmrd_pkg::dp_cmd_t    cmd
);
    import pmrd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MEM
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.accept   = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (status.mem_read) begin
                        state_next = ST_MEM;
                    end else begin
                        cmd.load_imm = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_MEM: begin
                cmd.load_mem = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/pmrd_datapath.sv =====
// ----------------------------------------------------------------------------
// pmrd_datapath
// Position, byte-select counter, configuration, byte store and result byte.
// ----------------------------------------------------------------------------
module pmrd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pmrd_pkg::FUNC_W-1:0]         s_func,
    input  logic [pmrd_pkg::BYTE_W-1:0]         s_wdata,
    output logic [pmrd_pkg::BYTE_W-1:0]         m_rdata,
    input  logic                                cfg_valid,
    input  logic [pmrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmrd_pkg::SIZE_W-1:0]         cfg_data,
    input  pmrd_pkg::dp_cmd_t                   cmd,
    output pmrd_pkg::dp_status_t                status
);
    import pmrd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        sel_reg, sel_next;
    logic              read_only_reg;
    logic [SIZE_W-1:0] disk_size_reg;
    logic              hit_reg;
    logic [BYTE_W-1:0] rdata_reg;

    logic [EXT_W-1:0]  eff_size;
    logic [EXT_W-1:0]  pos_ext;
    logic [EXT_W-1:0]  pos_inc;
    logic [EXT_W-1:0]  pos_sum;
    logic [EXT_W-1:0]  pos_sum_wrap;
    logic [POS_W-1:0]  pos_adv;
    logic              in_range;
    logic [BYTE_W-1:0] imm_rdata;
    logic [1:0]        seq_sel;
    logic              mem_we;
    logic              mem_re;
    logic [BYTE_W-1:0] mem_q;

    function automatic logic [POS_W-1:0] set_byte(logic [POS_W-1:0] p, logic [1:0] sel,
                                                  logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] r;
        r = p;
        case (sel)
            SEL_BYTE1: r[15:8]  = b;
            SEL_BYTE2: r[23:16] = b;
            default:   r[7:0]   = b;
        endcase
        return r;
    endfunction

    always_comb begin
        if (disk_size_reg == '0) begin
            eff_size = EXT_W'(1);
        end else if (EXT_W'(disk_size_reg) > EXT_W'(STORE_DEPTH)) begin
            eff_size = EXT_W'(STORE_DEPTH);
        end else begin
            eff_size = EXT_W'(disk_size_reg);
        end
    end

    assign pos_ext      = {1'b0, pos_reg};
    assign in_range     = pos_ext < eff_size;
    assign pos_inc      = pos_ext + EXT_W'(1);
    assign pos_adv      = (pos_inc >= eff_size) ? '0 : pos_inc[POS_W-1:0];
    assign pos_sum      = pos_ext + EXT_W'(s_wdata);
    assign pos_sum_wrap = (pos_sum >= eff_size) ? (pos_sum - eff_size) : pos_sum;
    assign seq_sel      = (sel_reg > SEL_BYTE2) ? SEL_BYTE0 : sel_reg;

    always_comb begin
        pos_next  = pos_reg;
        sel_next  = SEL_BYTE0;
        imm_rdata = '0;
        case (s_func)
            FN_RD_CTL, FN_WR_CTL: begin
                pos_next = '0;
            end
            FN_RD_DATA, FN_WR_DATA: begin
                pos_next = in_range ? pos_adv : '0;
            end
            FN_RD_ADDR0: imm_rdata = pos_reg[7:0];
            FN_RD_ADDR1: imm_rdata = pos_reg[15:8];
            FN_RD_ADDR2: imm_rdata = pos_reg[23:16];
            FN_WR_ADDR0: pos_next = set_byte(pos_reg, SEL_BYTE0, s_wdata);
            FN_WR_ADDR1: pos_next = set_byte(pos_reg, SEL_BYTE1, s_wdata);
            FN_WR_ADDR2: pos_next = set_byte(pos_reg, SEL_BYTE2, s_wdata);
            FN_WR_SEQ: begin
                pos_next = set_byte(pos_reg, seq_sel, s_wdata);
                sel_next = (seq_sel == SEL_BYTE2) ? SEL_BYTE0 : seq_sel + 2'd1;
            end
            FN_INC: begin
                pos_next = pos_sum_wrap[POS_W-1:0];
                sel_next = sel_reg;
            end
            default: begin
                sel_next = sel_reg;
            end
        endcase
    end

    assign status.mem_read = (s_func == FN_RD_DATA);
    assign mem_re = cmd.accept && (s_func == FN_RD_DATA);
    assign mem_we = cmd.accept && (s_func == FN_WR_DATA) && in_range && !read_only_reg;

    pmrd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (pos_reg[ADDR_W-1:0]),
        .wdata (s_wdata),
        .rdata (mem_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sel_reg       <= SEL_BYTE0;
            read_only_reg <= 1'b0;
            disk_size_reg <= SIZE_W'(65536);
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_READ_ONLY: read_only_reg <= cfg_data[0];
                    CFG_DISK_SIZE: disk_size_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                pos_reg <= pos_next;
                sel_reg <= sel_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            hit_reg <= in_range;
        end
        if (cmd.load_imm) begin
            rdata_reg <= imm_rdata;
        end else if (cmd.load_mem) begin
            rdata_reg <= hit_reg ? mem_q : '0;
        end
    end

    assign m_rdata = rdata_reg;

endmodule

// ===== hdl/pmrd_checker.sv =====
// ----------------------------------------------------------------------------
// pmrd_checker
// Port-level checks for the RAM disk core, bound to the top level.
// ----------------------------------------------------------------------------
module pmrd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [pmrd_pkg::FUNC_W-1:0]    s_func,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [pmrd_pkg::BYTE_W-1:0]    m_rdata
);
    import pmrd_pkg::*;

    logic s_acc;
    logic wr_item;

    assign s_acc   = s_valid && s_ready;
    assign wr_item = s_func inside {FN_RD_CTL, FN_WR_CTL, FN_WR_DATA, FN_WR_ADDR0,
                                    FN_WR_ADDR1, FN_WR_ADDR2, FN_WR_SEQ, FN_INC};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rdata))
        else $error("stalled result changed");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item taken while result stalled");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && wr_item |=> m_valid && (m_rdata == 8'd0))
        else $error("write or control item did not return zero");

    a_mem_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_func == FN_RD_DATA) |=> !m_valid && !s_ready ##1 m_valid)
        else $error("data read not delivered in second cycle");

endmodule

bind port_mapped_ram_disk_core pmrd_checker u_pmrd_checker (.*);
